// ===== rtl/ugcb_pkg.sv =====
// ============================================================================
// ugcb_pkg
// Shared types, codes and sizes of the uniform grid cell binner.
// ============================================================================
package ugcb_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DIM_DEF    = 32;

    localparam int POS_W   = 32;
    localparam int ID_W    = 16;
    localparam int DIM_W   = 6;
    localparam int SIZE_W  = 31;
    localparam int CELL_W  = 15;
    localparam int BOX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [2:0] REG_GRID_DIM  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE = 3'd4;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [ID_W-1:0]         point_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  found_id;
        logic [BOX_W-1:0] box_number;
        logic [BOX_W-1:0] box_begin;
        logic [LEN_W-1:0] box_length;
        logic             last;
    } res_t;

    function automatic res_t mk_res(
        input logic [1:0]       status,
        input logic [ID_W-1:0]  id,
        input logic [BOX_W-1:0] bn,
        input logic [BOX_W-1:0] bb,
        input logic [LEN_W-1:0] bl,
        input logic             last
    );
        res_t r;
        r.status     = status;
        r.found_id   = id;
        r.box_number = bn;
        r.box_begin  = bb;
        r.box_length = bl;
        r.last       = last;
        return r;
    endfunction

endpackage

// ===== rtl/ugcb_div.sv =====
// ============================================================================
// ugcb_div
// Restoring divider, one quotient bit per cycle, for the per-axis cell.
// ============================================================================
module ugcb_div
    import ugcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [POS_W-1:0]  quotient
);

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [POS_W-1:0]     shifted;
    logic [POS_W-1:0]     diff;
    logic                 ge;

    always_comb
    begin
        shifted    = {rem_reg, quo_reg[POS_W-1]};
        ge         = shifted >= {1'b0, divisor};
        diff       = shifted - {1'b0, divisor};
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quo_next   = {quo_reg[POS_W-2:0], ge};
            count_next = count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/uniform_grid_cell_binner.sv =====
// ============================================================================
// uniform_grid_cell_binner
// Bins 3D Q16.16 points into a cubic grid; answers neighbor queries and
// sorted-list builds over the stored points.
// ============================================================================
// One transaction at a time: cmd_stall is high from acceptance until the
// last result is loaded. Add and query first run one shared 32-step divider
// once per axis, for all three axes in turn. An add then passes through
// S_NB1, S_NB2, S_ADD and S_FINISH. A query visits 27 neighbor cells and,
// for each in-grid neighbor, scans every stored point. A build makes, for
// each populated cell, one min-search pass and one emit pass over the point
// memory through its one read port, and a last min-search pass that finds
// no further cell ends it. Results leave through one output register; a
// stalled output holds the sequencer.
module uniform_grid_cell_binner
    import ugcb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNW  = $clog2(MAX_POINTS + 1);
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int CMPW = CW + DIM_W;
    localparam int EW   = CELL_W + ID_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV_START = 4'd1;
    localparam logic [3:0] S_DIV_WAIT  = 4'd2;
    localparam logic [3:0] S_NB1       = 4'd3;
    localparam logic [3:0] S_NB2       = 4'd4;
    localparam logic [3:0] S_ADD       = 4'd5;
    localparam logic [3:0] S_SCAN_RD   = 4'd6;
    localparam logic [3:0] S_SCAN_CMP  = 4'd7;
    localparam logic [3:0] S_NEXT      = 4'd8;
    localparam logic [3:0] S_BMIN_RD   = 4'd9;
    localparam logic [3:0] S_BMIN_CMP  = 4'd10;
    localparam logic [3:0] S_BEMIT_RD  = 4'd11;
    localparam logic [3:0] S_BEMIT_CMP = 4'd12;
    localparam logic [3:0] S_FINISH    = 4'd13;

    localparam logic [1:0] OFF_DEC = 2'd0;
    localparam logic [1:0] OFF_MID = 2'd1;
    localparam logic [1:0] OFF_INC = 2'd2;

    function automatic logic [CW:0] nb_coord(
        input logic [CW-1:0]    c,
        input logic [1:0]       off,
        input logic [DIM_W-1:0] dim
    );
        logic [CW-1:0] n;
        logic          ok;
        case (off)
            OFF_DEC: n = c - CW'(1);
            OFF_INC: n = c + CW'(1);
            default: n = c;
        endcase
        ok = !(off == OFF_DEC && c == '0) && (CMPW'(n) < CMPW'(dim));
        return {ok, n};
    endfunction

    logic [3:0]              state_reg, state_next;
    logic [DIM_W-1:0]        grid_dim_reg;
    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [SIZE_W-1:0]       cell_size_reg;
    logic [CNW-1:0]          count_reg, count_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [1:0]              axis_reg, axis_next;
    logic                    outside_reg, outside_next;
    logic [CW-1:0]           cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [1:0]              ix_reg, ix_next, iy_reg, iy_next, iz_reg, iz_next;
    logic [CW-1:0]           nx_reg, nx_next;
    logic                    nb_ok_reg, nb_ok_next;
    logic [CELL_W-1:0]       t_reg, t_next;
    logic [CELL_W-1:0]       target_reg, target_next;
    logic [CNW-1:0]          e_reg, e_next;
    logic                    found_reg, found_next;
    logic [CELL_W-1:0]       prev_reg, prev_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [BOX_W-1:0]        box_reg, box_next;
    logic [BOX_W-1:0]        bpos_reg, bpos_next;
    res_t                    pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;
    res_t                    out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic [EW-1:0]           rd_entry_reg;
    logic [EW-1:0]           entry_mem [MAX_POINTS];

    logic [DIM_W-1:0]        dim_eff;
    logic [SIZE_W-1:0]       size_eff;
    logic signed [POS_W-1:0] pos_sel, org_sel;
    logic [POS_W:0]          diff;
    logic                    div_start, div_done;
    logic [POS_W-1:0]        quotient;
    logic                    mem_we;
    logic [CELL_W-1:0]       rd_cell;
    logic [ID_W-1:0]         rd_id;
    logic                    out_free, can_push, push_req;
    res_t                    push_val;
    logic [CW:0]             nbx, nby, nbz;
    logic                    cand;

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[ADDR_W-1:2])
            REG_GRID_DIM:  prdata = DATA_W'(grid_dim_reg);
            REG_ORIGIN_X:  prdata = DATA_W'(origin_x_reg);
            REG_ORIGIN_Y:  prdata = DATA_W'(origin_y_reg);
            REG_ORIGIN_Z:  prdata = DATA_W'(origin_z_reg);
            REG_CELL_SIZE: prdata = DATA_W'(cell_size_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_dim_reg  <= DIM_W'(1);
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            cell_size_reg <= SIZE_W'(65536);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_GRID_DIM:  grid_dim_reg  <= pwdata[DIM_W-1:0];
                REG_ORIGIN_X:  origin_x_reg  <= pwdata;
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata;
                REG_ORIGIN_Z:  origin_z_reg  <= pwdata;
                REG_CELL_SIZE: cell_size_reg <= pwdata[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_dim_reg == '0)
            dim_eff = DIM_W'(1);
        else if (grid_dim_reg > DIM_W'(MAX_DIM))
            dim_eff = DIM_W'(MAX_DIM);
        else
            dim_eff = grid_dim_reg;
        size_eff = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;
        case (axis_reg)
            2'd0:
            begin
                pos_sel = cmd_reg.pos_x;
                org_sel = origin_x_reg;
            end
            2'd1:
            begin
                pos_sel = cmd_reg.pos_y;
                org_sel = origin_y_reg;
            end
            default:
            begin
                pos_sel = cmd_reg.pos_z;
                org_sel = origin_z_reg;
            end
        endcase
        diff = {pos_sel[POS_W-1], pos_sel} - {org_sel[POS_W-1], org_sel};
    end

    ugcb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff[POS_W-1:0]),
        .divisor  (size_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[count_reg[AW-1:0]] <= {target_reg, cmd_reg.point_id};
        rd_entry_reg <= entry_mem[e_reg[AW-1:0]];
    end

    assign rd_cell = rd_entry_reg[EW-1:ID_W];
    assign rd_id   = rd_entry_reg[ID_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        axis_next       = axis_reg;
        outside_next    = outside_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        iz_next         = iz_reg;
        nx_next         = nx_reg;
        nb_ok_next      = nb_ok_reg;
        t_next          = t_reg;
        target_next     = target_reg;
        e_next          = e_reg;
        found_next      = found_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        len_next        = len_reg;
        box_next        = box_reg;
        bpos_next       = bpos_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_free        = !out_valid_reg || !res_stall;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && res_stall;
        can_push        = !pend_valid_reg || out_free;
        push_req        = 1'b0;
        push_val        = mk_res(ST_OK, rd_id, '0, '0, '0, 1'b0);
        div_start       = 1'b0;
        mem_we          = 1'b0;
        nbx             = nb_coord(cx_reg, ix_reg, dim_eff);
        nby             = nb_coord(cy_reg, iy_reg, dim_eff);
        nbz             = nb_coord(cz_reg, iz_reg, dim_eff);
        cand            = !prev_valid_reg || (rd_cell > prev_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    pend_valid_next = 1'b0;
                    e_next          = '0;
                    if (cmd.op == OP_BUILD)
                    begin
                        found_next      = 1'b0;
                        prev_valid_next = 1'b0;
                        box_next        = '0;
                        bpos_next       = '0;
                        state_next      = S_BMIN_RD;
                    end
                    else if (cmd.op == OP_NONE)
                        state_next = S_FINISH;
                    else
                    begin
                        axis_next    = '0;
                        outside_next = 1'b0;
                        state_next   = S_DIV_START;
                    end
                end
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (diff[POS_W] || quotient >= POS_W'(dim_eff))
                        outside_next = 1'b1;
                    case (axis_reg)
                        2'd0:    cx_next = quotient[CW-1:0];
                        2'd1:    cy_next = quotient[CW-1:0];
                        default: cz_next = quotient[CW-1:0];
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        if (outside_next)
                        begin
                            pend_next       = mk_res(ST_OUTSIDE, '0, '0, '0, '0, 1'b0);
                            pend_valid_next = 1'b1;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            ix_next    = (cmd_reg.op == OP_ADD) ? OFF_MID : OFF_DEC;
                            iy_next    = ix_next;
                            iz_next    = ix_next;
                            state_next = S_NB1;
                        end
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_NB1:
            begin
                nb_ok_next = nbx[CW] && nby[CW] && nbz[CW];
                nx_next    = nbx[CW-1:0];
                t_next     = CELL_W'(CELL_W'(nbz[CW-1:0]) * CELL_W'(dim_eff)
                                     + CELL_W'(nby[CW-1:0]));
                state_next = S_NB2;
            end
            S_NB2:
            begin
                target_next = CELL_W'(t_reg * CELL_W'(dim_eff) + CELL_W'(nx_reg));
                e_next      = '0;
                if (cmd_reg.op == OP_ADD)
                    state_next = S_ADD;
                else if (!nb_ok_reg)
                    state_next = S_NEXT;
                else
                    state_next = S_SCAN_RD;
            end
            S_ADD:
            begin
                if (count_reg >= CNW'(MAX_POINTS))
                    pend_next = mk_res(ST_FULL, '0, '0, '0, '0, 1'b0);
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNW'(1);
                    pend_next  = mk_res(ST_OK, '0, '0, '0, '0, 1'b0);
                end
                pend_valid_next = 1'b1;
                state_next      = S_FINISH;
            end
            S_SCAN_RD:
            begin
                if (e_reg == count_reg)
                    state_next = S_NEXT;
                else
                    state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                push_req = (rd_cell == target_reg);
                if (!push_req || can_push)
                begin
                    e_next     = e_reg + CNW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_NEXT:
            begin
                state_next = S_NB1;
                if (iz_reg != OFF_INC)
                    iz_next = iz_reg + 2'd1;
                else if (iy_reg != OFF_INC)
                begin
                    iy_next = iy_reg + 2'd1;
                    iz_next = OFF_DEC;
                end
                else if (ix_reg != OFF_INC)
                begin
                    ix_next = ix_reg + 2'd1;
                    iy_next = OFF_DEC;
                    iz_next = OFF_DEC;
                end
                else
                    state_next = S_FINISH;
            end
            S_BMIN_RD:
            begin
                if (e_reg == count_reg)
                begin
                    e_next     = '0;
                    state_next = found_reg ? S_BEMIT_RD : S_FINISH;
                end
                else
                    state_next = S_BMIN_CMP;
            end
            S_BMIN_CMP:
            begin
                if (cand)
                begin
                    if (!found_reg || rd_cell < target_reg)
                    begin
                        target_next = rd_cell;
                        len_next    = LEN_W'(1);
                        found_next  = 1'b1;
                    end
                    else if (rd_cell == target_reg)
                        len_next = len_reg + LEN_W'(1);
                end
                e_next     = e_reg + CNW'(1);
                state_next = S_BMIN_RD;
            end
            S_BEMIT_RD:
            begin
                if (e_reg == count_reg)
                begin
                    bpos_next       = BOX_W'(LEN_W'(bpos_reg) + len_reg);
                    box_next        = box_reg + BOX_W'(1);
                    prev_next       = target_reg;
                    prev_valid_next = 1'b1;
                    found_next      = 1'b0;
                    e_next          = '0;
                    state_next      = S_BMIN_RD;
                end
                else
                    state_next = S_BEMIT_CMP;
            end
            S_BEMIT_CMP:
            begin
                push_req = (rd_cell == target_reg);
                push_val = mk_res(ST_OK, rd_id, box_reg, bpos_reg, len_reg, 1'b0);
                if (!push_req || can_push)
                begin
                    e_next     = e_reg + CNW'(1);
                    state_next = S_BEMIT_RD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                        out_next = mk_res(ST_EMPTY, '0, '0, '0, '0, 1'b1);
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (push_req && can_push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = push_val;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            axis_reg       <= '0;
            outside_reg    <= 1'b0;
            e_reg          <= '0;
            found_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            ix_reg         <= '0;
            iy_reg         <= '0;
            iz_reg         <= '0;
            nb_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            axis_reg       <= axis_next;
            outside_reg    <= outside_next;
            e_reg          <= e_next;
            found_reg      <= found_next;
            prev_valid_reg <= prev_valid_next;
            ix_reg         <= ix_next;
            iy_reg         <= iy_next;
            iz_reg         <= iz_next;
            nb_ok_reg      <= nb_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        nx_reg     <= nx_next;
        t_reg      <= t_next;
        target_reg <= target_next;
        prev_reg   <= prev_next;
        len_reg    <= len_next;
        box_reg    <= box_next;
        bpos_reg   <= bpos_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== tb/uniform_grid_cell_binner_tb.sv =====
// ============================================================================
// uniform_grid_cell_binner_tb
// Self-checking bench: drives add, query, build and no-op transactions,
// predicts the result stream in a behavioral grid model, checks every one.
// ============================================================================
module uniform_grid_cell_binner_tb;
    import ugcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              cmd_valid;
    logic              cmd_stall;
    cmd_t              cmd;
    logic              res_valid;
    logic              res_stall;
    res_t              res;

    uniform_grid_cell_binner dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int MDIM = MAX_DIM_DEF;

    logic [DIM_W-1:0]  grid_dim_q;
    logic [POS_W-1:0]  org_q [3];
    logic [SIZE_W-1:0] size_q;
    logic [CELL_W-1:0] bin_cell [NPTS];
    logic [ID_W-1:0]   bin_id [NPTS];
    int                bin_count;

    res_t expected_results [$];
    int   fail_count;
    int   send_idle_pct;
    int   stall_pct;
    bit   stall_hold;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report(input string what, input res_t got, input res_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic queue_expected(input res_t r);
        expected_results = {expected_results, r};
    endtask

    function automatic longint axis_index(input logic [POS_W-1:0] p,
                                          input logic [POS_W-1:0] o);
        longint s;
        longint d;
        s = longint'(size_q);
        if (s < 1)
            s = 1;
        d = longint'($signed(p)) - longint'($signed(o));
        if (d >= 0)
            return d / s;
        return -((-d + s - 1) / s);
    endfunction

    function automatic res_t mk(input logic [1:0] st, input logic [ID_W-1:0] id,
                                input int bn, input int bb, input int bl,
                                input bit lst);
        res_t r;
        r.status     = st;
        r.found_id   = id;
        r.box_number = BOX_W'(bn);
        r.box_begin  = BOX_W'(bb);
        r.box_length = LEN_W'(bl);
        r.last       = lst;
        return r;
    endfunction

    task automatic predict_grid(input cmd_t c);
        longint dim;
        longint cx, cy, cz, nx, ny, nz, cidx, prev, best;
        int     n, bpos, box, len;
        res_t   outs [$];
        dim = longint'(grid_dim_q);
        if (dim < 1)
            dim = 1;
        if (dim > MDIM)
            dim = MDIM;
        if (c.op == OP_BUILD)
        begin
            prev = -1;
            bpos = 0;
            box  = 0;
            forever
            begin
                best = -1;
                for (int e = 0; e < bin_count; e++)
                    if (longint'(bin_cell[e]) > prev && (best < 0 || longint'(bin_cell[e]) < best))
                        best = longint'(bin_cell[e]);
                if (best < 0)
                    break;
                len = 0;
                for (int e = 0; e < bin_count; e++)
                    if (longint'(bin_cell[e]) == best)
                        len++;
                for (int e = 0; e < bin_count; e++)
                    if (longint'(bin_cell[e]) == best && outs.size() < NPTS)
                        outs = {outs, mk(ST_OK, bin_id[e], box, bpos, len, 1'b0)};
                bpos += len;
                box++;
                prev = best;
            end
        end
        else if (c.op == OP_NONE)
        begin
            queue_expected(mk(ST_EMPTY, 0, 0, 0, 0, 1'b1));
            return;
        end
        else
        begin
            cx = axis_index(c.pos_x, org_q[0]);
            cy = axis_index(c.pos_y, org_q[1]);
            cz = axis_index(c.pos_z, org_q[2]);
            if (cx < 0 || cy < 0 || cz < 0 || cx >= dim || cy >= dim || cz >= dim)
            begin
                queue_expected(mk(ST_OUTSIDE, 0, 0, 0, 0, 1'b1));
                return;
            end
            if (c.op == OP_ADD)
            begin
                if (bin_count >= NPTS)
                begin
                    queue_expected(mk(ST_FULL, 0, 0, 0, 0, 1'b1));
                    return;
                end
                bin_cell[bin_count] = CELL_W'(cx + cy * dim + cz * dim * dim);
                bin_id[bin_count]   = c.point_id;
                bin_count++;
                queue_expected(mk(ST_OK, 0, 0, 0, 0, 1'b1));
                return;
            end
            for (int i = -1; i <= 1; i++)
                for (int j = -1; j <= 1; j++)
                    for (int k = -1; k <= 1; k++)
                    begin
                        nx = cx + i;
                        ny = cy + j;
                        nz = cz + k;
                        if (nx < 0 || ny < 0 || nz < 0 || nx >= dim || ny >= dim || nz >= dim)
                            continue;
                        cidx = nx + ny * dim + nz * dim * dim;
                        for (int e = 0; e < bin_count; e++)
                            if (longint'(bin_cell[e]) == cidx && outs.size() < NPTS)
                                outs = {outs, mk(ST_OK, bin_id[e], 0, 0, 0, 1'b0)};
                    end
        end
        n = outs.size();
        if (n == 0)
            outs = {outs, mk(ST_EMPTY, 0, 0, 0, 0, 1'b1)};
        else
            outs[n-1].last = 1'b1;
        foreach (outs[q])
            queue_expected(outs[q]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                    report("unexpected", res, '0);
                else
                begin
                    res_t w;
                    w = expected_results.pop_front();
                    if (res.status !== w.status)
                        report("status", res, w);
                    if (res.found_id !== w.found_id)
                        report("found_id", res, w);
                    if (res.box_number !== w.box_number)
                        report("box_number", res, w);
                    if (res.box_begin !== w.box_begin)
                        report("box_begin", res, w);
                    if (res.box_length !== w.box_length)
                        report("box_length", res, w);
                    if (res.last !== w.last)
                        report("last", res, w);
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct) || stall_hold;
        end
    end

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_grid(c);
    endtask

    task automatic drain;
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_GRID_DIM:  grid_dim_q = v[DIM_W-1:0];
            REG_ORIGIN_X:  org_q[0] = v;
            REG_ORIGIN_Y:  org_q[1] = v;
            REG_ORIGIN_Z:  org_q[2] = v;
            REG_CELL_SIZE: size_q = v[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input int dim, input int ox, input int oy, input int oz,
                            input int sz);
        drain();
        write_reg(REG_GRID_DIM, DATA_W'(dim));
        write_reg(REG_ORIGIN_X, DATA_W'(ox));
        write_reg(REG_ORIGIN_Y, DATA_W'(oy));
        write_reg(REG_ORIGIN_Z, DATA_W'(oz));
        write_reg(REG_CELL_SIZE, DATA_W'(sz));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z,
                                    input logic [15:0] id);
        cmd_t c;
        c.op = op;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.point_id = id;
        return c;
    endfunction

    function automatic logic [31:0] rand_pos(input logic [31:0] org, input int span);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return $urandom();
        if (r < 9)
            return (r == 6) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return org + 32'($urandom_range(span)) - 32'($urandom_range(span / 16));
    endfunction

    task automatic test_directed;
        send_cmd(mk_cmd(OP_BUILD, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_QUERY, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_cmd(mk_cmd(OP_ADD, 32'h0000_8000, 0, 32'h0000_FFFF, 16'hFFFF));
        send_cmd(mk_cmd(OP_ADD, 32'h0001_0000, 0, 0, 16'h0001));
        send_cmd(mk_cmd(OP_ADD, 32'hFFFF_FFFF, 0, 0, 16'h0002));
        send_cmd(mk_cmd(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h0003));
        set_grid(0, 0, 0, 0, 0);
        send_cmd(mk_cmd(OP_ADD, 0, 0, 0, 16'h0000));
        send_cmd(mk_cmd(OP_ADD, 1, 0, 0, 16'h0004));
        set_grid(63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(mk_cmd(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234));
        send_cmd(mk_cmd(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h5678));
        send_cmd(mk_cmd(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0));
        send_cmd(mk_cmd(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        send_cmd(mk_cmd(OP_BUILD, 0, 0, 0, 0));
        set_grid(32, 0, 0, 0, 32'h0001_0000);
        for (int i = 0; i < 6; i++)
            send_cmd(mk_cmd(OP_ADD, 32'(i) << 16, 32'(31 - i) << 16, 32'(31) << 16,
                            16'(16'hA000 + i)));
        send_cmd(mk_cmd(OP_QUERY, 32'h0002_0000, 32'h001D_0000, 32'h001F_8000, 0));
        send_cmd(mk_cmd(OP_BUILD, 0, 0, 0, 0));
    endtask

    task automatic test_random(input int count, input int dim, input int sz);
        logic [31:0] o [3];
        int          span;
        int          r;
        logic [1:0]  op;
        for (int a = 0; a < 3; a++)
            o[a] = $urandom();
        set_grid(dim, o[0], o[1], o[2], sz);
        span = dim * sz;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            op = (r < 62) ? OP_ADD : (r < 88) ? OP_QUERY : (r < 96) ? OP_BUILD : OP_NONE;
            send_cmd(mk_cmd(op, rand_pos(o[0], span), rand_pos(o[1], span),
                            rand_pos(o[2], span), 16'($urandom())));
            if (n == count / 2)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_valid = 1'b0;
        cmd = '0;
        res_stall = 1'b0;
        stall_hold = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        fail_count = 0;
        bin_count = 0;
        grid_dim_q = 1;
        org_q[0] = 0;
        org_q[1] = 0;
        org_q[2] = 0;
        size_q = 31'd65536;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 53;
        test_random(50, 3, 32'h0001_0000);
        send_idle_pct = 0;
        stall_pct = 53;
        test_random(50, 2, 32'h0000_0100);
        send_idle_pct = 19;
        stall_pct = 19;
        test_random(50, 32, 1);
        send_idle_pct = 0;
        stall_pct = 0;
        test_random(60, 4, 32'h7FFF_FFFF);
        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ugcb_pkg.sv
rtl/ugcb_div.sv
rtl/uniform_grid_cell_binner.sv
tb/uniform_grid_cell_binner_tb.sv
